// File: sv/fmpi_pkg.sv
// fmpi_pkg: types, widths and constants of the figure micro point interpolator
// no dependencies; compiled first and used by the interfaces and the core

package fmpi_pkg;

	localparam int WORD_W = 32;
	localparam int MAG_W  = WORD_W + 1;
	localparam int CNT_W  = 7;
	localparam int PTS_W  = 11;
	localparam int PROD_W = PTS_W + CNT_W;
	localparam int LANES  = 4;
	localparam int LANE_W = $clog2(LANES);
	localparam int BIT_W  = $clog2(MAG_W);

	// largest segment count and largest micro point total per figure
	localparam logic [CNT_W-1:0]  RESULT_LIMIT     = CNT_W'(64);
	localparam logic [PROD_W-1:0] MAX_MICRO_POINTS = PROD_W'(1023);
	localparam logic [CNT_W-1:0]  CFG_RESET        = CNT_W'(1);

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [MAG_W-1:0]         mag_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic [PTS_W-1:0]         pts_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_ADV,
		ST_EMIT
	} state_t;

endpackage

// File: sv/fmpi_point_if.sv
// fmpi_point_if: valid/ready channel carrying one figure point
// depends on fmpi_pkg

interface fmpi_point_if;
	logic             valid;
	logic             ready;
	fmpi_pkg::word_t  pos_x;
	fmpi_pkg::word_t  pos_y;
	fmpi_pkg::word_t  core_power;
	fmpi_pkg::word_t  ring_power;
	logic             first_of_figure;
	fmpi_pkg::pts_t   figure_points;

	modport source (output valid, pos_x, pos_y, core_power, ring_power,
		first_of_figure, figure_points, input ready);
	modport sink (input valid, pos_x, pos_y, core_power, ring_power,
		first_of_figure, figure_points, output ready);
endinterface

// File: sv/fmpi_micro_if.sv
// fmpi_micro_if: valid/ready channel carrying one micro point
// depends on fmpi_pkg

interface fmpi_micro_if;
	logic             valid;
	logic             ready;
	fmpi_pkg::word_t  out_x;
	fmpi_pkg::word_t  out_y;
	fmpi_pkg::word_t  out_core_power;
	fmpi_pkg::word_t  out_ring_power;
	logic             last_of_run;

	modport source (output valid, out_x, out_y, out_core_power, out_ring_power,
		last_of_run, input ready);
	modport sink (input valid, out_x, out_y, out_core_power, out_ring_power,
		last_of_run, output ready);
endinterface

// File: sv/fmpi_cfg_if.sv
// fmpi_cfg_if: valid/ready write channel for the interp_count register
// depends on fmpi_pkg

interface fmpi_cfg_if;
	logic            valid;
	logic            ready;
	fmpi_pkg::cnt_t  interp_count;

	modport source (output valid, interp_count, input ready);
	modport sink (input valid, interp_count, output ready);
endinterface

// File: sv/figure_micro_point_interpolator_core.sv
// figure_micro_point_interpolator_core: top level of the micro point interpolator
// depends on fmpi_pkg, fmpi_point_if, fmpi_micro_if and fmpi_cfg_if
//
// Usage:
//  points : figure points in, one transaction per point (x, y, core and ring
//           power in signed Q15.16, first_of_figure, figure_points).
//  micro  : micro points out, last_of_run set on the final one of each point.
//  cfg    : write transaction to interp_count (N), taken at any time; change
//           it only while the block is idle.
// A point that passes through unchanged gives one result in the cycle after
// it is taken. An interpolated point first runs one shared restoring divider
// over the four channels in turn, then forms the first micro point in ST_ADV;
// its N results (N capped at 64) then leave one per cycle while micro is
// ready. The next point can be taken in the cycle after the last result leaves.
// points.ready is high only while no point is in progress.
// When the receiver stalls the current micro point is held unchanged.
// Reset clears the previous point to zero, the figure pass-through flag,
// and sets interp_count to 1. The config channel is always ready.

module figure_micro_point_interpolator_core (
	input  logic                 clk,
	input  logic                 arst_n,
	fmpi_point_if.sink           points,
	fmpi_micro_if.source         micro,
	fmpi_cfg_if.sink             cfg
);
	import fmpi_pkg::*;

	state_t              state_q, state_d;
	logic                pass_q;
	logic                plain_q;
	cnt_t                cfg_q;
	cnt_t                n_q;
	cnt_t                idx_q;
	word_t               prev_q  [LANES];
	word_t               base_q  [LANES];
	logic                neg_q   [LANES];
	mag_t                mag_q   [LANES];
	mag_t                quo_a_q [LANES];
	cnt_t                rem_b_q [LANES];
	mag_t                acc_q_q [LANES];
	logic [CNT_W:0]      acc_r_q [LANES];
	logic [LANE_W-1:0]   lane_q;
	logic [BIT_W-1:0]    bit_q;
	mag_t                dvd_q;
	cnt_t                drem_q;

	logic                in_fire, out_fire, cfg_fire;
	cnt_t                n_eff;
	logic [PROD_W-1:0]   size_prod;
	logic                figure_pass;
	logic                go_plain;
	word_t               in_word   [LANES];
	logic signed [MAG_W-1:0] in_diff [LANES];
	mag_t                in_mag    [LANES];
	logic [CNT_W:0]      div_trial;
	logic                div_ge;
	cnt_t                div_rem_nx;
	mag_t                div_dvd_nx;
	logic                div_done;
	logic                last_lane;
	logic [CNT_W+1:0]    upd_sum   [LANES];
	logic [CNT_W:0]      two_n;
	logic                upd_wrap  [LANES];
	logic [CNT_W:0]      upd_r_nx  [LANES];
	mag_t                upd_q_nx  [LANES];
	logic [MAG_W:0]      out_ext   [LANES];
	logic [MAG_W:0]      out_sum   [LANES];
	word_t               out_val   [LANES];
	logic                run_last;

	// handshakes
	assign points.ready = (state_q == ST_IDLE);
	assign cfg.ready    = 1'b1;
	assign in_fire      = points.valid & points.ready;
	assign cfg_fire     = cfg.valid & cfg.ready;
	assign out_fire     = micro.valid & micro.ready;

	// effective segment count and figure size test
	assign n_eff       = (cfg_q > RESULT_LIMIT) ? RESULT_LIMIT : cfg_q;
	assign size_prod   = PROD_W'(points.figure_points - PTS_W'(1)) * PROD_W'(n_eff);
	assign figure_pass = (n_eff <= CNT_W'(1)) || (points.figure_points == '0)
		|| (size_prod > MAX_MICRO_POINTS);
	assign go_plain    = points.first_of_figure || pass_q || (n_eff <= CNT_W'(1));

	// segment difference magnitudes per channel
	assign in_word[0] = points.pos_x;
	assign in_word[1] = points.pos_y;
	assign in_word[2] = points.core_power;
	assign in_word[3] = points.ring_power;
	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			in_diff[k] = MAG_W'(in_word[k]) - MAG_W'(prev_q[k]);
			in_mag[k]  = in_diff[k][MAG_W-1] ? mag_t'(-in_diff[k]) : mag_t'(in_diff[k]);
		end
	end

	// shared restoring divider step: |d| / N, one quotient bit per cycle
	assign div_trial  = {drem_q, dvd_q[MAG_W-1]};
	assign div_ge     = div_trial >= {1'b0, n_q};
	assign div_rem_nx = div_ge ? CNT_W'(div_trial - {1'b0, n_q}) : CNT_W'(div_trial);
	assign div_dvd_nx = {dvd_q[MAG_W-2:0], div_ge};
	assign div_done   = (bit_q == BIT_W'(MAG_W - 1));
	assign last_lane  = (lane_q == LANE_W'(LANES - 1));

	// step update: q += A, r += 2B, wrap once r reaches 2N
	assign two_n = {n_q, 1'b0};
	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			upd_sum[k]  = {1'b0, acc_r_q[k]} + {1'b0, rem_b_q[k], 1'b0};
			upd_wrap[k] = upd_sum[k] >= {1'b0, two_n};
			upd_r_nx[k] = upd_wrap[k] ? (CNT_W+1)'(upd_sum[k] - {1'b0, two_n})
				: (CNT_W+1)'(upd_sum[k]);
			upd_q_nx[k] = acc_q_q[k] + quo_a_q[k] + mag_t'(upd_wrap[k]);
		end
	end

	// micro point values: start plus signed rounded accumulated step, or the point itself on pass-through
	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			out_ext[k] = {{2{base_q[k][WORD_W-1]}}, base_q[k]};
			out_sum[k] = neg_q[k] ? (out_ext[k] - {1'b0, acc_q_q[k]})
				: (out_ext[k] + {1'b0, acc_q_q[k]});
			out_val[k] = plain_q ? prev_q[k] : word_t'(out_sum[k][WORD_W-1:0]);
		end
	end

	assign run_last             = plain_q || (idx_q == n_q);
	assign micro.valid          = (state_q == ST_EMIT);
	assign micro.out_x          = out_val[0];
	assign micro.out_y          = out_val[1];
	assign micro.out_core_power = out_val[2];
	assign micro.out_ring_power = out_val[3];
	assign micro.last_of_run    = run_last;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) state_d = go_plain ? ST_EMIT : ST_DIV;
			end
			ST_DIV: begin
				if (div_done && last_lane) state_d = ST_ADV;
			end
			ST_ADV: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_fire && run_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q  <= 1'b0;
			cfg_q   <= CFG_RESET;
			for (int k = 0; k < LANES; k++) prev_q[k] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_fire) cfg_q <= cfg.interp_count;
			if (in_fire) begin
				if (points.first_of_figure) pass_q <= figure_pass;
				for (int k = 0; k < LANES; k++) prev_q[k] <= in_word[k];
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					plain_q <= go_plain;
					n_q     <= n_eff;
					idx_q   <= CNT_W'(1);
					lane_q  <= '0;
					bit_q   <= '0;
					drem_q  <= '0;
					dvd_q   <= in_mag[0];
					for (int k = 0; k < LANES; k++) begin
						base_q[k] <= prev_q[k];
						neg_q[k]  <= in_diff[k][MAG_W-1];
						mag_q[k]  <= in_mag[k];
					end
				end
			end
			ST_DIV: begin
				if (div_done) begin
					quo_a_q[lane_q] <= div_dvd_nx;
					rem_b_q[lane_q] <= div_rem_nx;
					lane_q          <= lane_q + LANE_W'(1);
					bit_q           <= '0;
					drem_q          <= '0;
					dvd_q           <= mag_q[lane_q + LANE_W'(1)];
					if (last_lane) begin
						for (int k = 0; k < LANES; k++) begin
							acc_q_q[k] <= '0;
							acc_r_q[k] <= {1'b0, n_q};
						end
					end
				end else begin
					bit_q  <= bit_q + BIT_W'(1);
					drem_q <= div_rem_nx;
					dvd_q  <= div_dvd_nx;
				end
			end
			ST_ADV: begin
				for (int k = 0; k < LANES; k++) begin
					acc_q_q[k] <= upd_q_nx[k];
					acc_r_q[k] <= upd_r_nx[k];
				end
			end
			ST_EMIT: begin
				if (out_fire && !run_last) begin
					idx_q <= idx_q + CNT_W'(1);
					for (int k = 0; k < LANES; k++) begin
						acc_q_q[k] <= upd_q_nx[k];
						acc_r_q[k] <= upd_r_nx[k];
					end
				end
			end
			default: ;
		endcase
	end

endmodule
